@@ rtl/core/dmat_pkg.sv @@
package dmat_pkg;

  // Window geometry
  localparam int unsigned WinLen = 10;
  localparam int unsigned SLOT_W = (WinLen > 1) ? $clog2(WinLen) : 1;
  localparam int unsigned CNT_W  = $clog2(WinLen + 1);

  // Lanes carry a 17-bit signed sample so one lane serves both channels.
  localparam int unsigned SMP_W  = 17;
  localparam int unsigned SUM_W  = SMP_W + $clog2(WinLen);
  localparam int unsigned MAG_W  = SUM_W - 1;
  localparam int unsigned STEP_W = $clog2(MAG_W);

  // Config register indexes
  localparam logic [1:0] REG_TEMP_WARN = 2'd0;
  localparam logic [1:0] REG_TEMP_ALRM = 2'd1;
  localparam logic [1:0] REG_HUM_ALRM  = 2'd2;

  localparam logic signed [15:0] TEMP_WARN_RST = 16'sd10240;
  localparam logic signed [15:0] TEMP_ALRM_RST = 16'sd12800;
  localparam logic        [15:0] HUM_ALRM_RST  = 16'd23040;

  // Alert level codes
  localparam logic [1:0] LVL_NORMAL  = 2'd0;
  localparam logic [1:0] LVL_WARNING = 2'd1;
  localparam logic [1:0] LVL_ALARM   = 2'd2;

  typedef struct packed {
    logic signed [15:0] temperature_sample;
    logic        [15:0] humidity_sample;
    logic               sample_valid;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] temp_average;
    logic        [15:0] humidity_average;
    logic        [1:0]  alert_level;
    logic        [31:0] alarm_count;
  } result_t;

  typedef struct packed {
    logic              push;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } lane_ctrl_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] mean;
  } lane_stat_t;

  typedef struct packed {
    logic push;
    logic load;
  } merge_ctrl_t;

endpackage

@@ rtl/core/dmat_lane.sv @@
module dmat_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dmat_pkg::lane_ctrl_t              ctrl_i,
  input  logic signed [dmat_pkg::SMP_W-1:0] sample_i,
  output dmat_pkg::lane_stat_t              stat_o
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_LOAD = 2'd1;
  localparam logic [1:0] L_RUN  = 2'd2;

  logic signed [dmat_pkg::SMP_W-1:0] win_q [dmat_pkg::WinLen];
  logic signed [dmat_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [1:0]                        st_q;
  logic [dmat_pkg::STEP_W-1:0]       step_q;
  logic [dmat_pkg::MAG_W-1:0]        quo_q, quo_nx, mag, res;
  logic [dmat_pkg::CNT_W-1:0]        rem_q, div_q;
  logic [dmat_pkg::CNT_W:0]          rem_sh, rem_nx;
  logic                              neg_q, ge;
  logic [15:0]                       mean_q;

  always_comb begin
    sum_d = sum_q - dmat_pkg::SUM_W'(win_q[ctrl_i.slot]) + dmat_pkg::SUM_W'(sample_i);
    mag   = sum_q[dmat_pkg::SUM_W-1] ? dmat_pkg::MAG_W'(-sum_q) : dmat_pkg::MAG_W'(sum_q);
    // restoring divide, one quotient bit per cycle
    rem_sh = {rem_q, quo_q[dmat_pkg::MAG_W-1]};
    ge     = (rem_sh >= {1'b0, div_q});
    rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
    quo_nx = {quo_q[dmat_pkg::MAG_W-2:0], ge};
    res    = neg_q ? (-quo_nx) : quo_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dmat_pkg::WinLen; i++) win_q[i] <= '0;
      sum_q  <= '0;
      st_q   <= L_IDLE;
      step_q <= '0;
      mean_q <= '0;
    end else begin
      case (st_q)
        L_IDLE: begin
          if (ctrl_i.push) begin
            win_q[ctrl_i.slot] <= sample_i;
            sum_q <= sum_d;
            st_q  <= L_LOAD;
          end
        end
        L_LOAD: begin
          step_q <= '0;
          st_q   <= L_RUN;
        end
        L_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == dmat_pkg::STEP_W'(dmat_pkg::MAG_W - 1)) begin
            mean_q <= res[15:0];
            st_q   <= L_IDLE;
          end
        end
        default: st_q <= L_IDLE;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (st_q == L_IDLE && ctrl_i.push) begin
      div_q <= ctrl_i.count;
    end
    if (st_q == L_LOAD) begin
      quo_q <= mag;
      rem_q <= '0;
      neg_q <= sum_q[dmat_pkg::SUM_W-1];
    end else if (st_q == L_RUN) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx[dmat_pkg::CNT_W-1:0];
    end
  end

  assign stat_o.busy = (st_q != L_IDLE);
  assign stat_o.mean = mean_q;

endmodule

@@ rtl/core/dmat_merge.sv @@
module dmat_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmat_pkg::merge_ctrl_t ctrl_i,
  input  dmat_pkg::sample_t     sample_i,
  input  logic signed [15:0]    temp_warn_i,
  input  logic signed [15:0]    temp_alrm_i,
  input  logic        [15:0]    hum_alrm_i,
  input  dmat_pkg::lane_stat_t  temp_stat_i,
  input  dmat_pkg::lane_stat_t  hum_stat_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output dmat_pkg::result_t     out_req_o
);

  logic [1:0]        level_q;
  logic [31:0]       count_q;
  logic              out_valid_q;
  dmat_pkg::result_t out_q;
  logic              is_alarm, is_warn;

  assign is_alarm = (sample_i.temperature_sample >= temp_alrm_i) ||
                    (sample_i.humidity_sample >= hum_alrm_i);
  assign is_warn  = (sample_i.temperature_sample >= temp_warn_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= dmat_pkg::LVL_NORMAL;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.push) begin
        if (is_alarm) begin
          level_q <= dmat_pkg::LVL_ALARM;
          count_q <= count_q + 32'd1;
        end else if (is_warn) begin
          level_q <= dmat_pkg::LVL_WARNING;
        end else begin
          level_q <= dmat_pkg::LVL_NORMAL;
        end
      end
      if (ctrl_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      out_q.temp_average     <= temp_stat_i.mean;
      out_q.humidity_average <= hum_stat_i.mean;
      out_q.alert_level      <= level_q;
      out_q.alarm_count      <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

@@ rtl/core/dual_moving_average_threshold_alarm.sv @@
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------
// input    | in_valid_i / in_ready_o   | in_req_i  (dmat_pkg::sample_t)
// output   | out_valid_o / out_ready_i | out_req_o (dmat_pkg::result_t)
// config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// A valid sample goes from accept to the result register through the
// bit-serial divider in each lane; an invalid sample skips the divider.
// One request is in flight at a time.
// The result register frees the input side: a new request is taken while the
// previous result still waits for out_ready_i.
// Reset (async, active low) clears windows, sums, means, level and counter.
module dual_moving_average_threshold_alarm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dmat_pkg::sample_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dmat_pkg::result_t out_req_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for a request
  localparam logic [1:0] ST_DIV  = 2'd1;  // lanes dividing
  localparam logic [1:0] ST_FIN  = 2'd2;  // result waits for the output register

  logic [1:0]                    state_q, state_d;
  logic [dmat_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [dmat_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic signed [15:0]            temp_warn_q, temp_alrm_q;
  logic        [15:0]            hum_alrm_q;
  dmat_pkg::sample_t             smp_q;
  logic                          accept, push, lanes_busy, out_free;
  dmat_pkg::lane_ctrl_t          lane_ctrl;
  dmat_pkg::lane_stat_t          temp_stat, hum_stat;
  dmat_pkg::merge_ctrl_t         merge_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && in_req_i.sample_valid;
  assign lanes_busy = temp_stat.busy || hum_stat.busy;
  assign out_free   = !out_valid_o || out_ready_i;

  // shared write slot and fill count, advanced once per valid sample
  always_comb begin
    slot_d = (slot_q == dmat_pkg::SLOT_W'(dmat_pkg::WinLen - 1)) ? '0 : slot_q + 1'b1;
    cnt_d  = (cnt_q == dmat_pkg::CNT_W'(dmat_pkg::WinLen)) ? cnt_q : cnt_q + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = in_req_i.sample_valid ? ST_DIV : ST_FIN;
      ST_DIV:  if (!lanes_busy) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign lane_ctrl.push  = push;
  assign lane_ctrl.slot  = slot_q;
  assign lane_ctrl.count = cnt_d;

  // classification runs on the live request; loading waits in ST_FIN for a free output
  assign merge_ctrl.push = push;
  assign merge_ctrl.load = (state_q == ST_FIN) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      cnt_q       <= '0;
      temp_warn_q <= dmat_pkg::TEMP_WARN_RST;
      temp_alrm_q <= dmat_pkg::TEMP_ALRM_RST;
      hum_alrm_q  <= dmat_pkg::HUM_ALRM_RST;
    end else begin
      state_q <= state_d;
      if (push) begin
        slot_q <= slot_d;
        cnt_q  <= cnt_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dmat_pkg::REG_TEMP_WARN: temp_warn_q <= cfg_wdata_i;
          dmat_pkg::REG_TEMP_ALRM: temp_alrm_q <= cfg_wdata_i;
          dmat_pkg::REG_HUM_ALRM:  hum_alrm_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // request copy, feeds the merge stage outside the accept cycle
  always_ff @(posedge clk_i) begin
    if (accept) smp_q <= in_req_i;
  end

  dmat_lane u_temp_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .sample_i (dmat_pkg::SMP_W'(in_req_i.temperature_sample)),
    .stat_o   (temp_stat)
  );

  dmat_lane u_hum_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .sample_i ($signed({1'b0, in_req_i.humidity_sample})),
    .stat_o   (hum_stat)
  );

  dmat_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (merge_ctrl),
    .sample_i    (accept ? in_req_i : smp_q),
    .temp_warn_i (temp_warn_q),
    .temp_alrm_i (temp_alrm_q),
    .hum_alrm_i  (hum_alrm_q),
    .temp_stat_i (temp_stat),
    .hum_stat_i  (hum_stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o)
  );

endmodule

@@ rtl/core/dmat_checker.sv @@
module dmat_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input dmat_pkg::sample_t in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dmat_pkg::result_t out_req_o
);

  // result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result dropped or changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // an invalid sample on a free output skips the divider and is loaded from ST_FIN
  a_inv_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_req_i.sample_valid && !out_valid_o
    |-> ##2 out_valid_o)
    else $error("invalid sample result late");

  // counter moves by at most one between consecutive results
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o ||
      (out_req_o.alarm_count == $past(out_req_o.alarm_count)) ||
      (out_req_o.alarm_count == $past(out_req_o.alarm_count) + 32'd1))
    else $error("alarm count jumped");

endmodule

bind dual_moving_average_threshold_alarm dmat_checker u_dmat_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // Index past the register list; writes there must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES  = 8;
  localparam int PLAN_ROWS   = 21;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  dmat_pkg::sample_t in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  dmat_pkg::result_t out_req_o;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [15:0]       cfg_wdata_i;

  dual_moving_average_threshold_alarm u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Directed table; want is used only where typed is set.
  typedef struct {
    logic signed [15:0] temp;
    logic        [15:0] hum;
    bit                 valid;
    bit                 typed;
    dmat_pkg::result_t  want;
  } row_t;

  row_t plan [PLAN_ROWS] = '{
    // nothing taken yet: all zero
    '{16'sd0,      16'd0,     1'b0, 1'b1, '{16'sd0, 16'd0, dmat_pkg::LVL_NORMAL, 32'd0}},
    '{-16'sd1,     16'hFFFF,  1'b0, 1'b1, '{16'sd0, 16'd0, dmat_pkg::LVL_NORMAL, 32'd0}},
    // top of both ranges, first sample: mean is the sample
    '{16'sd32767,  16'hFFFF,  1'b1, 1'b1,
      '{16'sd32767, 16'hFFFF, dmat_pkg::LVL_ALARM, 32'd1}},
    // bottom of both ranges: -1/2 truncates to zero, 65535/2 to 32767
    '{-16'sd32768, 16'd0,     1'b1, 1'b1,
      '{16'sd0, 16'd32767, dmat_pkg::LVL_NORMAL, 32'd1}},
    // invalid repeats the last result
    '{16'sd1234,   16'hABCD,  1'b0, 1'b1,
      '{16'sd0, 16'd32767, dmat_pkg::LVL_NORMAL, 32'd1}},
    '{16'sd10240,  16'd0,     1'b1, 1'b0, '0},   // warning exactly at limit
    '{16'sd10239,  16'd0,     1'b1, 1'b0, '0},   // one below warning
    '{16'sd12800,  16'd0,     1'b1, 1'b0, '0},   // temp alarm exactly at limit
    '{16'sd12799,  16'd23039, 1'b1, 1'b0, '0},   // both just below alarm
    '{-16'sd32768, 16'd23040, 1'b1, 1'b0, '0},   // humidity alarm alone
    '{-16'sd1,     16'd1,     1'b1, 1'b0, '0},
    '{-16'sd256,   16'd0,     1'b1, 1'b0, '0},
    '{16'sd0,      16'd0,     1'b1, 1'b0, '0},
    '{16'sd5120,   16'd12800, 1'b1, 1'b0, '0},
    '{-16'sd32768, 16'd0,     1'b1, 1'b0, '0},   // window full before this row
    '{-16'sd32768, 16'd0,     1'b1, 1'b0, '0},
    '{-16'sd32768, 16'd0,     1'b1, 1'b0, '0},   // oldest evicted
    '{16'sd32767,  16'hFFFF,  1'b1, 1'b0, '0},
    '{16'sd32767,  16'hFFFF,  1'b1, 1'b0, '0},
    '{16'sd7,      16'd9,     1'b0, 1'b0, '0},
    '{16'sd1,      16'd2,     1'b1, 1'b0, '0}
  };

  // Mirror of the block's state
  logic signed [15:0] warn_lim;
  logic signed [15:0] alarm_lim;
  logic        [15:0] hum_lim;
  logic signed [15:0] temp_hist [dmat_pkg::WinLen];
  logic        [15:0] hum_hist  [dmat_pkg::WinLen];
  int                 next_slot;
  int                 fill;
  int                 temp_total;
  int unsigned        hum_total;
  logic signed [15:0] mean_t;
  logic        [15:0] mean_h;
  logic        [1:0]  level;
  logic        [31:0] alarms;

  dmat_pkg::result_t due_results [$];
  int      mismatches;
  int      requests_taken;
  int      valid_taken;
  int      results_seen;
  int      settings_used;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Window update, mean and classification for one accepted request.
  function automatic dmat_pkg::result_t advance_window(dmat_pkg::sample_t s);
    logic signed [15:0] t;
    logic        [15:0] h;
    dmat_pkg::result_t  r;
    t = s.temperature_sample;
    h = s.humidity_sample;
    if (s.sample_valid) begin
      temp_total = temp_total - int'(temp_hist[next_slot]) + int'(t);
      hum_total  = hum_total - 32'(hum_hist[next_slot]) + 32'(h);
      temp_hist[next_slot] = t;
      hum_hist[next_slot]  = h;
      next_slot = (next_slot + 1 >= dmat_pkg::WinLen) ? 0 : next_slot + 1;
      if (fill < dmat_pkg::WinLen) fill++;
      mean_t = 16'(temp_total / fill);       // truncates toward zero
      mean_h = 16'(hum_total / unsigned'(fill));
      if (t >= alarm_lim || h >= hum_lim) begin
        level  = dmat_pkg::LVL_ALARM;
        alarms = alarms + 32'd1;
      end else if (t >= warn_lim) begin
        level = dmat_pkg::LVL_WARNING;
      end else begin
        level = dmat_pkg::LVL_NORMAL;
      end
    end
    r.temp_average     = mean_t;
    r.humidity_average = mean_h;
    r.alert_level      = level;
    r.alarm_count      = alarms;
    return r;
  endfunction

  function automatic int around(int c, int spread, int lo, int hi);
    int v;
    v = c + int'($urandom_range(2 * spread)) - spread;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Random request: mostly valid, values often clustered around the active limits, else random or at range extremes.
  function automatic dmat_pkg::sample_t draw_sample();
    dmat_pkg::sample_t s;
    int                h_top;
    h_top = (hum_lim > 0) ? int'(hum_lim) - 1 : 0;
    s.sample_valid = ($urandom_range(99) < 85);
    case ($urandom_range(4))
      0: begin
        s.temperature_sample = 16'($urandom);
        s.humidity_sample    = 16'($urandom);
      end
      1: begin
        s.temperature_sample = 16'(around(warn_lim, 400, -32768, 32767));
        s.humidity_sample    = 16'($urandom_range(h_top));
      end
      2: begin
        s.temperature_sample = 16'(around(alarm_lim, 400, -32768, 32767));
        s.humidity_sample    = 16'($urandom_range(h_top));
      end
      3: begin
        s.temperature_sample = 16'($urandom);
        s.humidity_sample    = 16'(around(hum_lim, 400, 0, 65535));
      end
      default: begin
        case ($urandom_range(3))
          0: s.temperature_sample = 16'sh7FFF;
          1: s.temperature_sample = 16'sh8000;
          2: s.temperature_sample = -16'sd1;
          default: s.temperature_sample = 16'sd0;
        endcase
        s.humidity_sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
    endcase
    return s;
  endfunction

  // Offer one request; prediction happens at the accepting edge.
  task automatic offer_sample(dmat_pkg::sample_t s, bit typed, dmat_pkg::result_t want);
    int                gap;
    dmat_pkg::result_t r;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    r = advance_window(s);
    due_results.push_back(typed ? want : r);
    requests_taken++;
    if (s.sample_valid) valid_taken++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Block must be idle here.
  task automatic load_limits(logic signed [15:0] w, logic signed [15:0] a,
                             logic [15:0] h, bit poke_spare);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= dmat_pkg::REG_TEMP_WARN;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= dmat_pkg::REG_TEMP_ALRM;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_idx_i   <= dmat_pkg::REG_HUM_ALRM;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    if (poke_spare) begin
      cfg_idx_i   <= REG_SPARE;
      cfg_wdata_i <= 16'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    warn_lim  = w;
    alarm_lim = a;
    hum_lim   = h;
    settings_used++;
  endtask

  task automatic score_result(dmat_pkg::result_t got);
    dmat_pkg::result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      $error("result with no request pending: %h", got);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      if (got.temp_average !== want.temp_average) begin
        $error("temp_average: expected %0d, got %0d",
               $signed(want.temp_average), $signed(got.temp_average));
        mismatches++;
      end
      if (got.humidity_average !== want.humidity_average) begin
        $error("humidity_average: expected %0d, got %0d",
               want.humidity_average, got.humidity_average);
        mismatches++;
      end
      if (got.alert_level !== want.alert_level) begin
        $error("alert_level: expected %0d, got %0d", want.alert_level, got.alert_level);
        mismatches++;
      end
      if (got.alarm_count !== want.alarm_count) begin
        $error("alarm_count: expected %0d, got %0d", want.alarm_count, got.alarm_count);
        mismatches++;
      end
    end
  endtask

  // Result side: check at the accepting edge, then pick next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) score_result(out_req_o);
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    dmat_pkg::sample_t s;
    dmat_pkg::result_t none;
    int                taken;

    none = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b1;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = dmat_pkg::REG_TEMP_WARN;
    cfg_wdata_i = '0;

    warn_lim  = dmat_pkg::TEMP_WARN_RST;
    alarm_lim = dmat_pkg::TEMP_ALRM_RST;
    hum_lim   = dmat_pkg::HUM_ALRM_RST;
    for (int i = 0; i < dmat_pkg::WinLen; i++) begin
      temp_hist[i] = '0;
      hum_hist[i]  = '0;
    end
    next_slot  = 0;
    fill       = 0;
    temp_total = 0;
    hum_total  = 0;
    mean_t     = '0;
    mean_h     = '0;
    level      = dmat_pkg::LVL_NORMAL;
    alarms     = '0;
    mismatches = 0;
    requests_taken = 0;
    valid_taken    = 0;
    results_seen   = 0;
    settings_used  = 1;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_left      = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset limits
    for (int i = 0; i < PLAN_ROWS; i++) begin
      s.temperature_sample = plan[i].temp;
      s.humidity_sample    = plan[i].hum;
      s.sample_valid       = plan[i].valid;
      offer_sample(s, plan[i].typed, plan[i].typed ? plan[i].want : none);
    end

    // Random phases, each under its own limits and idle mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      repeat (4) @(posedge clk_i);
      case (p)
        0: load_limits(dmat_pkg::TEMP_WARN_RST, dmat_pkg::TEMP_ALRM_RST,
                       dmat_pkg::HUM_ALRM_RST, 1'b0);
        1: load_limits(16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0);   // warn floor, alarm ceiling
        2: load_limits(16'sh7FFF, 16'sh8000, 16'h0000, 1'b0);   // inverted: all alarm
        4: load_limits(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);  // spare too
        7: load_limits(dmat_pkg::TEMP_WARN_RST, dmat_pkg::TEMP_ALRM_RST,
                       dmat_pkg::HUM_ALRM_RST, 1'b1);
        default: load_limits(16'(around(0, 12000, -32768, 32767)),
                             16'(around(6000, 12000, -32768, 32767)),
                             16'($urandom_range(65535)), 1'b0);
      endcase
      case (p)
        1, 5:    begin send_idle_pct = 46; stall_pct = 0;  end
        2, 6:    begin send_idle_pct = 0;  stall_pct = 46; end
        3, 7:    begin send_idle_pct = 33; stall_pct = 33; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      // Long receiver hold while requests keep coming: input side backs up.
      if (p == 4) hold_left = 300;
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        // Sender pause until every pending result is out.
        if (p == 4 && taken == PHASE_ITEMS / 2) drain_results();
        s = draw_sample();
        taken++;
        offer_sample(s, 1'b0, none);
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d requests (%0d valid) and %0d results, %0d alarms counted,",
             requests_taken, valid_taken, results_seen, alarms);
    $display("under %0d limit settings with idle, stall and back-pressure phases.",
             settings_used);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dmat_pkg.sv
rtl/core/dmat_lane.sv
rtl/core/dmat_merge.sv
rtl/core/dual_moving_average_threshold_alarm.sv
rtl/core/dmat_checker.sv
sim/testbench.sv
